>>> hw/rtl/tsq_pkg.sv
// types and constants shared by the two-stack queue
`default_nettype none

package tsq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 5;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0]         CAP_RESET   = CAP_W'(16);
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [DATA_W-1:0]  data_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  result_value;
        logic                      was_empty;
        logic                      was_dropped;
    } out_item_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [DATA_W-1:0]  wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } ram_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/tsq_ram.sv
// stack storage: one write port, one read port with registered read data
`default_nettype none

module tsq_ram
    import tsq_pkg::*;
(
    input  wire logic               clk,
    input  wire ram_req_t           req,
    output logic [DATA_W-1:0]       rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/two_stack_queue_top.sv
// top level of the first-in first-out queue built from two stacks
// usage:
//   in channel (in_valid/in_ready/in_data) carries one command per beat:
//   enqueue pushes data_value onto the inbox stack, dequeue pops the outbox.
//   out channel (out_valid/out_ready/out_data) returns exactly one beat per
//   command: the dequeued value, -1 with was_empty on an empty queue, or 0
//   with was_dropped set when an enqueue found the inbox at capacity.
//   cfg_we/cfg_data write capacity_limit; write it only while idle.
// timing:
//   one command at a time; in_ready is high only in the idle state.
//   an enqueue goes through DECIDE and RESULT; a dequeue from a non-empty outbox
//   goes through DECIDE, POP (the registered ram read) and RESULT; a dequeue that
//   finds the outbox empty first moves the inbox entries in XFER, one per cycle.
//   in_ready returns with out_valid.
// reset:
//   rst_n clears both counts, sets capacity_limit to 16, drops out_valid.
//   ram contents are not cleared; no entry is read before it is written.
// stall:
//   while an out beat is held, the next command is still accepted and worked up
//   to its own result, which then waits in a holding register with in_ready low.
`default_nettype none

module two_stack_queue_top
    import tsq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data
);

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_XFER,
        S_POP,
        S_RESULT
    } state_t;

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic [DATA_W-1:0]         din_reg, din_next;
    logic [CNT_W-1:0]          ic_reg, ic_next;
    logic [CNT_W-1:0]          oc_reg, oc_next;
    logic [CAP_W-1:0]          cap_reg, cap_next;
    out_item_t                 res_reg, res_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg, out_data_next;

    ram_req_t                  ib_req, ob_req;
    logic [DATA_W-1:0]         ib_rdata, ob_rdata;

    logic [CMP_W-1:0]          cap_eff;
    logic                      ic_full, oc_full;
    logic [CNT_W-1:0]          ic_dec, oc_dec;

    tsq_ram u_inbox
    (
        .clk   (clk),
        .req   (ib_req),
        .rdata (ib_rdata)
    );

    tsq_ram u_outbox
    (
        .clk   (clk),
        .req   (ob_req),
        .rdata (ob_rdata)
    );

    assign cap_eff = (CMP_W'(cap_reg) < CMP_W'(DEPTH)) ? CMP_W'(cap_reg) : CMP_W'(DEPTH);
    assign ic_full = CMP_W'(ic_reg) >= cap_eff;
    assign oc_full = CMP_W'(oc_reg) >= cap_eff;
    assign ic_dec  = ic_reg - CNT_W'(1);
    assign oc_dec  = oc_reg - CNT_W'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        din_next       = din_reg;
        ic_next        = ic_reg;
        oc_next        = oc_reg;
        cap_next       = cap_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ib_req         = '0;
        ob_req         = '0;

        if (cfg_we)
        begin
            cap_next = cfg_data;
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_data.cmd;
                    din_next   = in_data.data_value;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (cmd_reg == CMD_ENQ)
                begin
                    res_next.result_value = '0;
                    res_next.was_empty    = 1'b0;
                    res_next.was_dropped  = ic_full;
                    if (!ic_full)
                    begin
                        ib_req.we    = 1'b1;
                        ib_req.waddr = ic_reg[ADDR_W-1:0];
                        ib_req.wdata = din_reg;
                        ic_next      = ic_reg + CNT_W'(1);
                    end
                    state_next = S_RESULT;
                end
                else if (oc_reg != '0)
                begin
                    ob_req.re    = 1'b1;
                    ob_req.raddr = oc_dec[ADDR_W-1:0];
                    oc_next      = oc_dec;
                    state_next   = S_POP;
                end
                else if (ic_reg != '0)
                begin
                    ib_req.re    = 1'b1;
                    ib_req.raddr = ic_dec[ADDR_W-1:0];
                    ic_next      = ic_dec;
                    state_next   = S_XFER;
                end
                else
                begin
                    res_next.result_value = EMPTY_VALUE;
                    res_next.was_empty    = 1'b1;
                    res_next.was_dropped  = 1'b0;
                    state_next            = S_RESULT;
                end
            end
            S_XFER:
            begin
                // entries popped once the outbox is full are discarded
                if (!oc_full)
                begin
                    ob_req.we    = 1'b1;
                    ob_req.waddr = oc_reg[ADDR_W-1:0];
                    ob_req.wdata = ib_rdata;
                    oc_next      = oc_reg + CNT_W'(1);
                end
                if (ic_reg != '0)
                begin
                    ib_req.re    = 1'b1;
                    ib_req.raddr = ic_dec[ADDR_W-1:0];
                    ic_next      = ic_dec;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_POP:
            begin
                res_next.result_value = ob_rdata;
                res_next.was_empty    = 1'b0;
                res_next.was_dropped  = 1'b0;
                state_next            = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ic_reg        <= '0;
            oc_reg        <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ic_reg        <= ic_next;
            oc_reg        <= oc_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        din_reg      <= din_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/tsq_checker.sv
// port-level checks for the two-stack queue, bound to the top level
`default_nettype none

module tsq_checker
    import tsq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire out_item_t         out_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out beat changed while stalled");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second command taken while busy");

    // empty answer carries minus one
    a_empty_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.was_empty |-> out_data.result_value == EMPTY_VALUE)
        else $error("empty dequeue without minus one");

    // a dropped enqueue answers zero and is not an empty dequeue
    a_drop_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.was_dropped |->
            out_data.result_value == '0 && !out_data.was_empty)
        else $error("dropped enqueue with bad result");

endmodule

bind two_stack_queue_top tsq_checker u_tsq_checker (.*);

`default_nettype wire

>>> tb/sv/tb_two_stack_queue_top.sv
// testbench for two_stack_queue_top: queue scoreboard class, stimulus drivers and checks
`timescale 1ns / 1ps

class tsq_scoreboard;
    logic [31:0]         inbox_words[16];
    logic [31:0]         outbox_words[16];
    int unsigned         inbox_fill;
    int unsigned         outbox_fill;
    logic [4:0]          capacity;
    tsq_pkg::out_item_t  due_beats[$];
    int                  errors;

    function new();
        inbox_fill  = 0;
        outbox_fill = 0;
        capacity    = tsq_pkg::CAP_RESET;
        errors      = 0;
    endfunction

    function int pending();
        return due_beats.size();
    endfunction

    // works out the beat that one accepted command produces
    function void note_command(tsq_pkg::in_item_t cmd_beat);
        int unsigned        room;
        logic [31:0]        word;
        tsq_pkg::out_item_t due;
        room = (capacity < tsq_pkg::DEPTH) ? capacity : tsq_pkg::DEPTH;
        due = '0;
        if (cmd_beat.cmd == tsq_pkg::CMD_ENQ)
        begin
            if (inbox_fill >= room)
            begin
                due.was_dropped = 1'b1;
            end
            else
            begin
                inbox_words[inbox_fill] = cmd_beat.data_value;
                inbox_fill++;
            end
        end
        else
        begin
            if (outbox_fill == 0)
            begin
                // move inbox across; words past the outbox room are lost
                while (inbox_fill > 0)
                begin
                    inbox_fill--;
                    word = inbox_words[inbox_fill];
                    if (outbox_fill < room)
                    begin
                        outbox_words[outbox_fill] = word;
                        outbox_fill++;
                    end
                end
            end
            if (outbox_fill == 0)
            begin
                due.result_value = tsq_pkg::EMPTY_VALUE;
                due.was_empty    = 1'b1;
            end
            else
            begin
                outbox_fill--;
                due.result_value = outbox_words[outbox_fill];
            end
        end
        due_beats.push_back(due);
    endfunction

    task report_mismatch(input string msg);
        errors++;
        if (errors <= 100)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task check_beat(input tsq_pkg::out_item_t got);
        tsq_pkg::out_item_t want;
        if (due_beats.size() == 0)
        begin
            report_mismatch($sformatf("beat %h with nothing expected", got));
            return;
        end
        want = due_beats.pop_front();
        if (got.result_value !== want.result_value)
        begin
            report_mismatch($sformatf("result_value %h, expected %h",
                                      got.result_value, want.result_value));
        end
        if (got.was_empty !== want.was_empty)
        begin
            report_mismatch($sformatf("was_empty %b, expected %b",
                                      got.was_empty, want.was_empty));
        end
        if (got.was_dropped !== want.was_dropped)
        begin
            report_mismatch($sformatf("was_dropped %b, expected %b",
                                      got.was_dropped, want.was_dropped));
        end
    endtask
endclass

module tb_two_stack_queue_top;
    import tsq_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 185;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CAP_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;

    tsq_scoreboard     sb;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_cycles   = 0;
    int                quiet_cycles  = 0;

    two_stack_queue_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            sb.check_beat(out_data);
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input cmd_t op, input logic [31:0] word);
        in_item_t beat;
        beat.cmd        = op;
        beat.data_value = word;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_command(beat);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] limit);
        cfg_we   <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.capacity = limit;
    endtask

    task automatic run_phase(input int count, input bit with_hold);
        int enq_bias;
        int k;
        enq_bias = 50;
        for (k = 0; k < count; k++)
        begin
            if (k % 24 == 0)
            begin
                case ($urandom_range(2))
                    0: enq_bias = 15;
                    1: enq_bias = 50;
                    default: enq_bias = 85;
                endcase
            end
            // long receiver stall so the queue backs up into the input
            if (with_hold && k == 40)
            begin
                hold_cycles = 300;
            end
            send_item(($urandom_range(99) < enq_bias) ? CMD_ENQ : CMD_DEQ, pick_word());
        end
    endtask

    initial
    begin
        int ph;
        int k;
        logic [CAP_W-1:0] limit;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, field extremes and a stored minus one
        send_item(CMD_DEQ, $urandom);
        send_item(CMD_ENQ, 32'h7FFF_FFFF);
        send_item(CMD_ENQ, 32'h8000_0000);
        send_item(CMD_ENQ, 32'hFFFF_FFFF);
        send_item(CMD_ENQ, 32'h0000_0000);
        send_item(CMD_ENQ, 32'hA5A5_5A5A);
        for (k = 0; k < 6; k++)
        begin
            send_item(CMD_DEQ, $urandom);
        end

        // zero capacity drops the enqueue, and the dequeue finds the queue empty
        wait_drained();
        write_capacity(CAP_W'(0));
        send_item(CMD_ENQ, 32'h1234_5678);
        send_item(CMD_DEQ, $urandom);

        wait_drained();
        write_capacity(CAP_W'(1));
        send_item(CMD_ENQ, $urandom);
        send_item(CMD_ENQ, $urandom);
        send_item(CMD_DEQ, $urandom);

        // capacity lowered under a full inbox, transfer overflows the outbox
        wait_drained();
        write_capacity(CAP_W'(16));
        for (k = 0; k < 4; k++)
        begin
            send_item(CMD_ENQ, $urandom);
        end
        wait_drained();
        write_capacity(CAP_W'(2));
        for (k = 0; k < 3; k++)
        begin
            send_item(CMD_DEQ, $urandom);
        end

        for (ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: limit = CAP_W'(31);
                1: limit = CAP_W'(1);
                2: limit = CAP_W'(16);
                4: limit = CAP_W'(0);
                5: limit = CAP_W'(16);
                7: limit = CAP_W'(2);
                8: limit = CAP_W'(16);
                default: limit = CAP_W'($urandom_range(31));
            endcase
            wait_drained();
            write_capacity(limit);
            if (ph < 3)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 53;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase(PHASE_ITEMS, (ph == 0) || (ph == 3));
        end

        wait_drained();
        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d expected beats never came", sb.pending()));
        end
        if (sb.errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
